// File: rtl/core/aqes_pkg.sv
package aqes_pkg;

  localparam int CW     = 24;            // coefficient width
  localparam int SW     = 32;            // stress / gradient width
  localparam int PW     = 26;            // weight matrix entry width
  localparam int PRW    = PW + SW;       // one weight x stress product
  localparam int PVW    = 60;            // P*v lane width
  localparam int ACW    = 96;            // quadratic form width
  localparam int RTW    = ACW / 2;       // root width
  localparam int RMW    = RTW + 2;       // root remainder width
  localparam int NSQ    = ACW / 2;       // root cells, two radicand bits each
  localparam int NUMW   = 72;            // divider numerator width
  localparam int DENW   = 56;            // divider denominator width
  localparam int QW     = 32;            // quotient bits, one per divider cell
  localparam int DW     = DENW + QW - 1; // aligned divisor width
  localparam int NLANE  = 6;
  localparam int GRAD_FRAC = 20;

  // floor(m/9) = (m * K9_MUL) >> K9_SHIFT, exact for m < 2**27
  localparam logic [24:0] K9_MUL   = 25'd29826162;
  localparam int          K9_SHIFT = 28;

  localparam logic [2:0] REG_MODE = 3'd0;
  localparam logic [2:0] REG_F    = 3'd1;
  localparam logic [2:0] REG_G    = 3'd2;
  localparam logic [2:0] REG_H    = 3'd3;
  localparam logic [2:0] REG_L    = 3'd4;
  localparam logic [2:0] REG_M    = 3'd5;
  localparam logic [2:0] REG_N    = 3'd6;
  localparam logic [2:0] REG_K    = 3'd7;

  localparam logic [CW-1:0] RST_FGH = 24'd524288;
  localparam logic [CW-1:0] RST_LMN = 24'd1572864;

  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_BAD = 2'd1;
  localparam logic [1:0] ST_SAT = 2'd2;

  typedef struct packed {
    logic                        vld;
    logic                        bad;
    logic [ACW-1:0]              x;
    logic [RMW-1:0]              rem;
    logic [RTW-1:0]              root;
    logic [NLANE-1:0][PVW-1:0]   pv;
  } sq_t;

  typedef struct packed {
    logic                        vld;
    logic                        bad;
    logic [SW-1:0]               eq;
    logic                        eq_sat;
    logic [NLANE-1:0]            neg;
    logic [NLANE-1:0]            ovf;
    logic [NLANE-1:0][NUMW-1:0]  rem;
    logic [NLANE-1:0][QW-1:0]    q;
    logic [DW-1:0]               d;
  } dv_t;

endpackage

// File: rtl/core/aqes_if.sv
interface aqes_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] stress_11;
  logic signed [31:0] stress_22;
  logic signed [31:0] stress_33;
  logic signed [31:0] stress_12;
  logic signed [31:0] stress_13;
  logic signed [31:0] stress_23;

  modport source (output valid, stress_11, stress_22, stress_33, stress_12, stress_13,
                  stress_23, input ready);
  modport sink (input valid, stress_11, stress_22, stress_33, stress_12, stress_13,
                stress_23, output ready);
endinterface

interface aqes_out_if;
  logic               valid;
  logic               ready;
  logic [31:0]        equiv_stress;
  logic signed [31:0] grad_11;
  logic signed [31:0] grad_22;
  logic signed [31:0] grad_33;
  logic signed [31:0] grad_12;
  logic signed [31:0] grad_13;
  logic signed [31:0] grad_23;
  logic [1:0]         status_code;

  modport source (output valid, equiv_stress, grad_11, grad_22, grad_33, grad_12, grad_13,
                  grad_23, status_code, input ready);
  modport sink (input valid, equiv_stress, grad_11, grad_22, grad_33, grad_12, grad_13,
                grad_23, status_code, output ready);
endinterface

// File: rtl/core/aqes_sqrt_cell.sv
module aqes_sqrt_cell
  import aqes_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic en,
  input  sq_t  d_i,
  output sq_t  q_o
);

  logic [RMW+1:0] rem_sh;
  logic [RMW+1:0] trial;
  sq_t            q_nxt;
  sq_t            q_r;

  // one root bit: bring down two radicand bits, try 4*root+1
  always_comb begin
    rem_sh = {d_i.rem, d_i.x[ACW-1 -: 2]};
    trial  = {2'b00, d_i.root, 2'b01};
    q_nxt   = d_i;
    q_nxt.x = {d_i.x[ACW-3:0], 2'b00};
    if (rem_sh >= trial) begin
      q_nxt.rem  = RMW'(rem_sh - trial);
      q_nxt.root = {d_i.root[RTW-2:0], 1'b1};
    end else begin
      q_nxt.rem  = RMW'(rem_sh);
      q_nxt.root = {d_i.root[RTW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r <= '0;
    end else if (en) begin
      q_r <= q_nxt;
    end
  end

  assign q_o = q_r;

endmodule

// File: rtl/core/aqes_div_cell.sv
module aqes_div_cell
  import aqes_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic en,
  input  dv_t  d_i,
  output dv_t  q_o
);

  logic [NLANE-1:0][DW-1:0] rem_x;
  dv_t                      q_nxt;
  dv_t                      q_r;

  // one quotient bit per lane, divisor shared across lanes
  always_comb begin
    q_nxt   = d_i;
    q_nxt.d = d_i.d >> 1;
    for (int i = 0; i < NLANE; i++) begin
      rem_x[i] = DW'(d_i.rem[i]);
      if (rem_x[i] >= d_i.d) begin
        q_nxt.rem[i] = NUMW'(rem_x[i] - d_i.d);
        q_nxt.q[i]   = {d_i.q[i][QW-2:0], 1'b1};
      end else begin
        q_nxt.q[i]   = {d_i.q[i][QW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r <= '0;
    end else if (en) begin
      q_r <= q_nxt;
    end
  end

  assign q_o = q_r;

endmodule

// File: rtl/core/anisotropic_quadratic_equiv_stress_core.sv
// Hill / Deshpande-Fleck-Ashby equivalent stress, fixed point. Takes one Voigt
// stress beat (Q24.8, order 11,22,33,12,13,23) per clock and returns
// eq = floor(sqrt(v'Pv)) in Q24.8 plus the gradient Pv/eq in Q12.20.
// Throughput is one beat per cycle while the output is not held. The path is
// the matrix-vector and quadratic-form arithmetic stages, a chain of 48 square-root
// cells (two radicand bits each), one alignment stage, a chain of 32
// divider cells (one quotient bit each, six lanes sharing the divisor) and
// the output register. The whole chain stalls only while a result waits at
// the output. Configuration writes reach the weight matrix through registers;
// write only while the block is drained. status_code: 0 normal, 1 zero input,
// non-positive form or zero root (all fields zero), 2 some field saturated.
module anisotropic_quadratic_equiv_stress_core
  import aqes_pkg::*;
#(
  parameter int FRAC_BITS_COEF = 20
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_we,
  input  logic [2:0]    cfg_idx,
  input  logic [CW-1:0] cfg_wdata,
  aqes_in_if.sink       in_ch,
  aqes_out_if.source    out_ch
);

  // shift to Q.20 gradients: numerator up, or divisor up
  localparam int SH  = GRAD_FRAC - FRAC_BITS_COEF;
  localparam int NSH = (SH > 0) ? SH : 0;
  localparam int DSH = (SH < 0) ? -SH : 0;

  logic adv;

  // ---------------- configuration ----------------
  logic                 mode_r;
  logic signed [CW-1:0] coef_f_r, coef_g_r, coef_h_r;
  logic signed [CW-1:0] coef_l_r, coef_m_r, coef_n_r, coef_k_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= 1'b0;
      coef_f_r <= RST_FGH;
      coef_g_r <= RST_FGH;
      coef_h_r <= RST_FGH;
      coef_l_r <= RST_LMN;
      coef_m_r <= RST_LMN;
      coef_n_r <= RST_LMN;
      coef_k_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_MODE: mode_r   <= cfg_wdata[0];
        REG_F:    coef_f_r <= cfg_wdata;
        REG_G:    coef_g_r <= cfg_wdata;
        REG_H:    coef_h_r <= cfg_wdata;
        REG_L:    coef_l_r <= cfg_wdata;
        REG_M:    coef_m_r <= cfg_wdata;
        REG_N:    coef_n_r <= cfg_wdata;
        REG_K:    coef_k_r <= cfg_wdata;
        default:  ;
      endcase
    end
  end

  // K/9 truncated toward zero (zero in mode 0), via reciprocal multiply on the magnitude
  logic [CW-1:0]        k_mag;
  logic [CW+24:0]       k_prod;
  logic [CW-1:0]        k_q;
  logic signed [CW-1:0] k9_nxt, k9_r;

  always_comb begin
    k_mag  = coef_k_r[CW-1] ? CW'(-coef_k_r) : CW'(coef_k_r);
    k_prod = (CW+25)'(k_mag) * (CW+25)'(K9_MUL);
    k_q    = CW'(k_prod >> K9_SHIFT);
    k9_nxt = !mode_r ? '0 : (coef_k_r[CW-1] ? -$signed(k_q) : $signed(k_q));
  end

  always_ff @(posedge clk) begin
    k9_r <= k9_nxt;
  end

  // weight matrix: normal 3x3 block and three shear diagonals (12,13,23)
  logic signed [PW-1:0] pn_r [3][3];
  logic signed [PW-1:0] ps_r [3];
  logic signed [PW-1:0] f_x, g_x, h_x, k_x;

  always_comb begin
    f_x = PW'(coef_f_r);
    g_x = PW'(coef_g_r);
    h_x = PW'(coef_h_r);
    k_x = PW'(k9_r);
  end

  always_ff @(posedge clk) begin
    pn_r[0][0] <= g_x + h_x + k_x;
    pn_r[1][1] <= f_x + h_x + k_x;
    pn_r[2][2] <= f_x + g_x + k_x;
    pn_r[0][1] <= k_x - h_x;
    pn_r[1][0] <= k_x - h_x;
    pn_r[0][2] <= k_x - g_x;
    pn_r[2][0] <= k_x - g_x;
    pn_r[1][2] <= k_x - f_x;
    pn_r[2][1] <= k_x - f_x;
    ps_r[0]    <= PW'(coef_n_r) <<< 1;
    ps_r[1]    <= PW'(coef_m_r) <<< 1;
    ps_r[2]    <= PW'(coef_l_r) <<< 1;
  end

  // ---------------- front arithmetic ----------------
  // stall only while a finished result is held at the output
  assign adv         = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = adv;

  logic signed [SW-1:0]  v_in [NLANE];
  logic signed [PRW-1:0] s1_pn_nxt [3][3];
  logic signed [PRW-1:0] s1_ps_nxt [3];
  logic signed [PRW-1:0] s1_pn_r [3][3];
  logic signed [PRW-1:0] s1_ps_r [3];
  logic signed [SW-1:0]  s1_v_r [NLANE];
  logic                  s1_vld_r;

  always_comb begin
    v_in[0] = in_ch.stress_11;
    v_in[1] = in_ch.stress_22;
    v_in[2] = in_ch.stress_33;
    v_in[3] = in_ch.stress_12;
    v_in[4] = in_ch.stress_13;
    v_in[5] = in_ch.stress_23;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        s1_pn_nxt[i][j] = pn_r[i][j] * v_in[j];
      end
      s1_ps_nxt[i] = ps_r[i] * v_in[3+i];
    end
  end

  logic signed [PVW-1:0] s2_pv_nxt [NLANE];
  logic signed [PVW-1:0] s2_pv_r [NLANE];
  logic signed [SW-1:0]  s2_v_r [NLANE];
  logic                  s2_vld_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s2_pv_nxt[i]   = PVW'(s1_pn_r[i][0]) + PVW'(s1_pn_r[i][1]) + PVW'(s1_pn_r[i][2]);
      s2_pv_nxt[3+i] = PVW'(s1_ps_r[i]);
    end
  end

  // v'Pv lane products, pv split in two halves to keep multipliers narrow
  logic signed [62:0]    s3_lo_nxt [NLANE];
  logic signed [61:0]    s3_hi_nxt [NLANE];
  logic signed [62:0]    s3_lo_r [NLANE];
  logic signed [61:0]    s3_hi_r [NLANE];
  logic signed [PVW-1:0] s3_pv_r [NLANE];
  logic                  s3_vld_r;

  always_comb begin
    for (int i = 0; i < NLANE; i++) begin
      s3_lo_nxt[i] = $signed({1'b0, s2_pv_r[i][29:0]}) * s2_v_r[i];
      s3_hi_nxt[i] = $signed(s2_pv_r[i][PVW-1:30]) * s2_v_r[i];
    end
  end

  logic signed [ACW-1:0] s4_ln_nxt [NLANE];
  logic signed [ACW-1:0] s4_ln_r [NLANE];
  logic signed [PVW-1:0] s4_pv_r [NLANE];
  logic                  s4_vld_r;

  always_comb begin
    for (int i = 0; i < NLANE; i++) begin
      s4_ln_nxt[i] = (ACW'(s3_hi_r[i]) <<< 30) + ACW'(s3_lo_r[i]);
    end
  end

  logic signed [ACW-1:0] s5_acc_r;
  logic signed [PVW-1:0] s5_pv_r [NLANE];
  logic                  s5_vld_r;

  // radicand load into the root chain
  sq_t s6_nxt, s6_r;

  always_comb begin
    s6_nxt      = '0;
    s6_nxt.vld  = s5_vld_r;
    s6_nxt.bad  = s5_acc_r[ACW-1] || (s5_acc_r == '0);
    s6_nxt.x    = s6_nxt.bad ? '0 : (ACW'(s5_acc_r) >> FRAC_BITS_COEF);
    for (int i = 0; i < NLANE; i++) begin
      s6_nxt.pv[i] = s5_pv_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
      s4_vld_r <= 1'b0;
      s5_vld_r <= 1'b0;
      s6_r     <= '0;
    end else if (adv) begin
      s1_vld_r <= in_ch.valid;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
      s4_vld_r <= s3_vld_r;
      s5_vld_r <= s4_vld_r;
      s6_r     <= s6_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_pn_r  <= s1_pn_nxt;
      s1_ps_r  <= s1_ps_nxt;
      s1_v_r   <= v_in;
      s2_pv_r  <= s2_pv_nxt;
      s2_v_r   <= s1_v_r;
      s3_lo_r  <= s3_lo_nxt;
      s3_hi_r  <= s3_hi_nxt;
      s3_pv_r  <= s2_pv_r;
      s4_ln_r  <= s4_ln_nxt;
      s4_pv_r  <= s3_pv_r;
      s5_acc_r <= s4_ln_r[0] + s4_ln_r[1] + s4_ln_r[2]
                + s4_ln_r[3] + s4_ln_r[4] + s4_ln_r[5];
      s5_pv_r  <= s4_pv_r;
    end
  end

  // ---------------- square-root chain ----------------
  sq_t sq [NSQ+1];
  assign sq[0] = s6_r;

  for (genvar gi = 0; gi < NSQ; gi++) begin : g_sq
    aqes_sqrt_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (adv),
      .d_i   (sq[gi]),
      .q_o   (sq[gi+1])
    );
  end

  // ---------------- divider alignment ----------------
  sq_t               sq_end;
  logic [DENW-1:0]   den;
  logic [PVW-1:0]    mag;
  logic [NUMW-1:0]   num;
  dv_t               dv_nxt, dv0_r;

  assign sq_end = sq[NSQ];

  always_comb begin
    dv_nxt        = '0;
    dv_nxt.vld    = sq_end.vld;
    dv_nxt.bad    = sq_end.bad || (sq_end.root == '0);
    dv_nxt.eq_sat = |sq_end.root[RTW-1:SW];
    dv_nxt.eq     = dv_nxt.eq_sat ? '1 : sq_end.root[SW-1:0];
    den           = DENW'(sq_end.root) << DSH;
    dv_nxt.d      = {den, {(QW-1){1'b0}}};
    mag           = '0;
    num           = '0;
    for (int i = 0; i < NLANE; i++) begin
      dv_nxt.neg[i] = sq_end.pv[i][PVW-1];
      mag           = sq_end.pv[i][PVW-1] ? PVW'(-sq_end.pv[i]) : sq_end.pv[i];
      num           = NUMW'(mag) << NSH;
      dv_nxt.rem[i] = num;
      // quotient would need more than 32 bits
      dv_nxt.ovf[i] = {{(DENW+QW-NUMW){1'b0}}, num} >= {den, {QW{1'b0}}};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv0_r <= '0;
    end else if (adv) begin
      dv0_r <= dv_nxt;
    end
  end

  // ---------------- divider chain ----------------
  dv_t dv [QW+1];
  assign dv[0] = dv0_r;

  for (genvar gd = 0; gd < QW; gd++) begin : g_dv
    aqes_div_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (adv),
      .d_i   (dv[gd]),
      .q_o   (dv[gd+1])
    );
  end

  // ---------------- saturation and output register ----------------
  dv_t                  dv_end;
  logic [SW-1:0]        lim;
  logic [SW-1:0]        gmag;
  logic [NLANE-1:0]     gsat;
  logic signed [SW-1:0] grad_nxt [NLANE];
  logic [SW-1:0]        eq_nxt;
  logic [1:0]           st_nxt;

  assign dv_end = dv[QW];

  always_comb begin
    lim  = '0;
    gmag = '0;
    for (int i = 0; i < NLANE; i++) begin
      lim         = dv_end.neg[i] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
      gsat[i]     = dv_end.ovf[i] || (dv_end.q[i] > lim);
      gmag        = gsat[i] ? lim : dv_end.q[i];
      grad_nxt[i] = dv_end.neg[i] ? -$signed(gmag) : $signed(gmag);
    end
    eq_nxt = dv_end.eq;
    st_nxt = (dv_end.eq_sat || (|gsat)) ? ST_SAT : ST_OK;
    if (dv_end.bad) begin
      eq_nxt = '0;
      st_nxt = ST_BAD;
      for (int i = 0; i < NLANE; i++) begin
        grad_nxt[i] = '0;
      end
    end
  end

  logic                 out_vld_r;
  logic [SW-1:0]        out_eq_r;
  logic signed [SW-1:0] out_grad_r [NLANE];
  logic [1:0]           out_st_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= dv_end.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_eq_r   <= eq_nxt;
      out_grad_r <= grad_nxt;
      out_st_r   <= st_nxt;
    end
  end

  assign out_ch.valid        = out_vld_r;
  assign out_ch.equiv_stress = out_eq_r;
  assign out_ch.grad_11      = out_grad_r[0];
  assign out_ch.grad_22      = out_grad_r[1];
  assign out_ch.grad_33      = out_grad_r[2];
  assign out_ch.grad_12      = out_grad_r[3];
  assign out_ch.grad_13      = out_grad_r[4];
  assign out_ch.grad_23      = out_grad_r[5];
  assign out_ch.status_code  = out_st_r;

`ifndef SYNTH
  // degenerate results are all zero
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.status_code == ST_BAD |->
      out_ch.equiv_stress == '0 && out_ch.grad_11 == '0 && out_ch.grad_23 == '0)
    else $error("degenerate result not cleared");

  // a normal result has a nonzero root
  a_ok_root: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.status_code == ST_OK |-> out_ch.equiv_stress != '0)
    else $error("normal status with zero root");

  // a held result freezes the whole chain
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |-> !in_ch.ready)
    else $error("input taken while output stalled");

  // the root chain consumes every radicand bit
  a_sq_drain: assert property (@(posedge clk) disable iff (!rst_n)
    sq_end.vld |-> sq_end.x == '0)
    else $error("radicand bits left after root chain");
`endif

endmodule
